### src/bts_pkg.sv
package bts_pkg;

  // Texture geometry
  localparam int MAX_TEX_LOG2 = 6;
  localparam int TEX_ADDR_W   = 2 * MAX_TEX_LOG2;
  localparam int BANK_ADDR_W  = TEX_ADDR_W - 1;
  localparam int BANK_DEPTH   = 1 << BANK_ADDR_W;
  localparam int EFF_W        = $clog2(MAX_TEX_LOG2 + 1);

  // Field widths
  localparam int INDEX_W    = 12;
  localparam int COLOR_IN_W = 32;
  localparam int COORD_W    = 24;
  localparam int TEXEL_W    = 24;
  localparam int CHAN_W     = 8;
  localparam int FRAC_W     = 8;
  localparam int WEIGHT_W   = FRAC_W + 1;
  localparam int LOG2_W     = 3;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_TEX_SIZE_LOG2   = 1'b0;
  localparam logic [LOG2_W-1:0]    TEX_SIZE_LOG2_RESET = 3'd6;

  // Item function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // One texture bank access: one write port, two read ports
  typedef struct packed {
    logic                   wen;
    logic [BANK_ADDR_W-1:0] waddr;
    logic [TEXEL_W-1:0]     wdata;
    logic                   ren;
    logic [BANK_ADDR_W-1:0] raddr0;
    logic [BANK_ADDR_W-1:0] raddr1;
  } bank_req_t;

endpackage

### src/bts_bank.sv
module bts_bank (
  input  logic                             clk,
  input  bts_pkg::bank_req_t               req,
  output logic [bts_pkg::TEXEL_W-1:0]      rd0,
  output logic [bts_pkg::TEXEL_W-1:0]      rd1
);

  logic [bts_pkg::TEXEL_W-1:0] mem [bts_pkg::BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wen) begin
      mem[req.waddr] <= req.wdata;
    end
    // hold read data while ren is low, as when the consuming stage is stalled
    if (req.ren) begin
      rd0 <= mem[req.raddr0];
      rd1 <= mem[req.raddr1];
    end
  end

endmodule

### src/bilinear_texture_sampler.sv
// Channel   Direction  Handshake            Beat payload
// in        input      in_valid / in_stall  func, texel_index, texel_color, coord_u, coord_v
// out       output     out_valid/ out_stall color
// cfg       input      APB (psel/penable)   tex_size_log2 at byte address 0
//
// A beat can be accepted every cycle unless out_stall fills the pipe. Four register stages:
// address, bank read, multiply, sum; a sample beat's color leaves the sum stage register.
// A load beat writes its texel as it leaves the address stage and gives nothing.
// Two banks split by column parity, two read ports each, return all four neighbours.
// Reset clears the valid bits and sets tex_size_log2 to 6; texels are undefined until loaded.
// A stage advances when the one ahead is empty or moving, so bubbles close up.
module bilinear_texture_sampler (
  input  logic                                clk,
  input  logic                                rst,
  // input beats
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                func,
  input  logic [bts_pkg::INDEX_W-1:0]         texel_index,
  input  logic [bts_pkg::COLOR_IN_W-1:0]      texel_color,
  input  logic [bts_pkg::COORD_W-1:0]         coord_u,
  input  logic [bts_pkg::COORD_W-1:0]         coord_v,
  // result beats
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bts_pkg::TEXEL_W-1:0]         color,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bts_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [bts_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [bts_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int MAXL     = bts_pkg::MAX_TEX_LOG2;
  localparam int NUM_CHAN = bts_pkg::TEXEL_W / bts_pkg::CHAN_W;
  localparam int PROD_W   = bts_pkg::CHAN_W + bts_pkg::WEIGHT_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int WPROD_W  = 2 * bts_pkg::WEIGHT_W;

  localparam logic [MAXL:0]                   ONE_M  = 1;
  localparam logic [MAXL-1:0]                 ONE_X  = 1;
  localparam logic [bts_pkg::WEIGHT_W-1:0]    FULL_W = bts_pkg::WEIGHT_W'(1 << bts_pkg::FRAC_W);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [bts_pkg::LOG2_W-1:0]    tex_size_log2;
  logic [bts_pkg::REG_IDX_W-1:0] reg_idx;
  logic [bts_pkg::EFF_W-1:0]     eff_log2;

  assign reg_idx = paddr[bts_pkg::APB_ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_size_log2 <= bts_pkg::TEX_SIZE_LOG2_RESET;
    end else if (psel && penable && pwrite && pready &&
                 reg_idx == bts_pkg::REG_TEX_SIZE_LOG2) begin
      tex_size_log2 <= pwdata[bts_pkg::LOG2_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == bts_pkg::REG_TEX_SIZE_LOG2) begin
      prdata = bts_pkg::APB_DATA_W'(tex_size_log2);
    end
  end

  // clamp the size into the legal range
  always_comb begin
    if (tex_size_log2 == '0) begin
      eff_log2 = bts_pkg::EFF_W'(1);
    end else if (int'(tex_size_log2) > MAXL) begin
      eff_log2 = bts_pkg::EFF_W'(MAXL);
    end else begin
      eff_log2 = bts_pkg::EFF_W'(tex_size_log2);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage control: each stage loads when it is empty or its successor loads
  // ---------------------------------------------------------------------------
  logic a_valid, b_valid, c_valid;
  logic adv_a, adv_b, adv_c, adv_d;
  logic a_func;

  assign adv_d    = !out_valid || !out_stall;
  assign adv_c    = !c_valid || adv_d;
  assign adv_b    = !b_valid || adv_c;
  assign adv_a    = !a_valid || adv_b;
  assign in_stall = !adv_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_a) begin
        a_valid <= in_valid;
      end
      // loads retire in the bank stage
      if (adv_b) begin
        b_valid <= a_valid && (a_func == bts_pkg::FUNC_SAMPLE);
      end
      if (adv_c) begin
        c_valid <= b_valid;
      end
      if (adv_d) begin
        out_valid <= c_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Address generation (feeds stage A)
  // ---------------------------------------------------------------------------
  logic [MAXL:0]                      mask_full;
  logic [MAXL-1:0]                    mask, ix, iy, x0, x1, y0, y1, xe, xo;
  logic [bts_pkg::TEX_ADDR_W-1:0]     row0, row1, ev0, ev1, od0, od1;

  always_comb begin
    mask_full = (ONE_M << eff_log2) - ONE_M;
    mask      = mask_full[MAXL-1:0];
    ix        = coord_u[bts_pkg::FRAC_W +: MAXL];
    iy        = coord_v[bts_pkg::FRAC_W +: MAXL];
    x0        = ix & mask;
    x1        = (ix + ONE_X) & mask;
    y0        = iy & mask;
    y1        = (iy + ONE_X) & mask;
    row0      = bts_pkg::TEX_ADDR_W'(y0) << eff_log2;
    row1      = bts_pkg::TEX_ADDR_W'(y1) << eff_log2;
    // neighbour columns always differ in parity: one goes to each bank
    xe        = x0[0] ? x1 : x0;
    xo        = x0[0] ? x0 : x1;
    ev0       = row0 | bts_pkg::TEX_ADDR_W'(xe);
    ev1       = row1 | bts_pkg::TEX_ADDR_W'(xe);
    od0       = row0 | bts_pkg::TEX_ADDR_W'(xo);
    od1       = row1 | bts_pkg::TEX_ADDR_W'(xo);
  end

  // Stage A registers
  logic                                a_swap;
  logic [bts_pkg::BANK_ADDR_W-1:0]     a_ev0, a_ev1, a_od0, a_od1;
  logic [bts_pkg::TEX_ADDR_W-1:0]      a_widx;
  logic [bts_pkg::TEXEL_W-1:0]         a_wdata;
  logic [bts_pkg::FRAC_W-1:0]          a_fx, a_fy;

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_func  <= func;
      a_swap  <= x0[0];
      a_ev0   <= ev0[bts_pkg::TEX_ADDR_W-1:1];
      a_ev1   <= ev1[bts_pkg::TEX_ADDR_W-1:1];
      a_od0   <= od0[bts_pkg::TEX_ADDR_W-1:1];
      a_od1   <= od1[bts_pkg::TEX_ADDR_W-1:1];
      a_widx  <= bts_pkg::TEX_ADDR_W'(texel_index);
      a_wdata <= texel_color[bts_pkg::TEXEL_W-1:0];
      a_fx    <= coord_u[bts_pkg::FRAC_W-1:0];
      a_fy    <= coord_v[bts_pkg::FRAC_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: bank access and weights
  // ---------------------------------------------------------------------------
  bts_pkg::bank_req_t           ev_req, od_req;
  logic [bts_pkg::TEXEL_W-1:0]  ev_rd0, ev_rd1, od_rd0, od_rd1;
  logic                         do_load;

  assign do_load = adv_b && a_valid && (a_func == bts_pkg::FUNC_LOAD);

  always_comb begin
    ev_req.wen    = do_load && !a_widx[0];
    ev_req.waddr  = a_widx[bts_pkg::TEX_ADDR_W-1:1];
    ev_req.wdata  = a_wdata;
    ev_req.ren    = adv_b;
    ev_req.raddr0 = a_ev0;
    ev_req.raddr1 = a_ev1;
    od_req.wen    = do_load && a_widx[0];
    od_req.waddr  = a_widx[bts_pkg::TEX_ADDR_W-1:1];
    od_req.wdata  = a_wdata;
    od_req.ren    = adv_b;
    od_req.raddr0 = a_od0;
    od_req.raddr1 = a_od1;
  end

  bts_bank u_bank_even (
    .clk (clk),
    .req (ev_req),
    .rd0 (ev_rd0),
    .rd1 (ev_rd1)
  );

  bts_bank u_bank_odd (
    .clk (clk),
    .req (od_req),
    .rd0 (od_rd0),
    .rd1 (od_rd1)
  );

  logic [bts_pkg::WEIGHT_W-1:0] inv_fx, inv_fy, fx_w, fy_w;
  logic [WPROD_W-1:0]           p00, p10, p01, p11;

  always_comb begin
    fx_w   = bts_pkg::WEIGHT_W'(a_fx);
    fy_w   = bts_pkg::WEIGHT_W'(a_fy);
    inv_fx = FULL_W - fx_w;
    inv_fy = FULL_W - fy_w;
    p00    = WPROD_W'(inv_fx) * WPROD_W'(inv_fy);
    p10    = WPROD_W'(fx_w)   * WPROD_W'(inv_fy);
    p01    = WPROD_W'(inv_fx) * WPROD_W'(fy_w);
    p11    = WPROD_W'(fx_w)   * WPROD_W'(fy_w);
  end

  logic                         b_swap;
  logic [bts_pkg::WEIGHT_W-1:0] b_w [4];

  always_ff @(posedge clk) begin
    if (adv_b) begin
      b_swap <= a_swap;
      b_w[0] <= p00[bts_pkg::FRAC_W +: bts_pkg::WEIGHT_W];
      b_w[1] <= p10[bts_pkg::FRAC_W +: bts_pkg::WEIGHT_W];
      b_w[2] <= p01[bts_pkg::FRAC_W +: bts_pkg::WEIGHT_W];
      b_w[3] <= p11[bts_pkg::FRAC_W +: bts_pkg::WEIGHT_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: route bank data back to neighbour order, multiply by weights
  // ---------------------------------------------------------------------------
  logic [bts_pkg::TEXEL_W-1:0] tex [4];

  always_comb begin
    tex[0] = b_swap ? od_rd0 : ev_rd0;  // (x0, y0)
    tex[1] = b_swap ? ev_rd0 : od_rd0;  // (x1, y0)
    tex[2] = b_swap ? od_rd1 : ev_rd1;  // (x0, y1)
    tex[3] = b_swap ? ev_rd1 : od_rd1;  // (x1, y1)
  end

  logic [PROD_W-1:0] c_prod [NUM_CHAN][4];

  always_ff @(posedge clk) begin
    if (adv_c) begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        for (int k = 0; k < 4; k++) begin
          c_prod[ch][k] <= PROD_W'(tex[k][ch*bts_pkg::CHAN_W +: bts_pkg::CHAN_W]) *
                           PROD_W'(b_w[k]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: sum per channel, drop the weight fraction, output register
  // ---------------------------------------------------------------------------
  logic [ACC_W-1:0] acc [NUM_CHAN];

  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      acc[ch] = ACC_W'(c_prod[ch][0]) + ACC_W'(c_prod[ch][1]) +
                ACC_W'(c_prod[ch][2]) + ACC_W'(c_prod[ch][3]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv_d) begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        color[ch*bts_pkg::CHAN_W +: bts_pkg::CHAN_W] <=
          acc[ch][bts_pkg::FRAC_W +: bts_pkg::CHAN_W];
      end
    end
  end

endmodule
